@@ design/brk4_pkg.sv @@
// Package for the Brusselator RK4 step unit: fixed-point types, payload
// structs, config register indexes and saturating arithmetic helpers.
// No dependencies.
package brk4_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 24;
  localparam int RegFrac   = 24;
  localparam int StepWidth = 25;
  localparam int RateWidth = 29;

  typedef logic signed [DataWidth-1:0]   fix_t;
  typedef logic signed [2*DataWidth-1:0] prod_t;

  localparam fix_t FixMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam fix_t FixMin = {1'b1, {(DataWidth-1){1'b0}}};

  // config register indexes
  typedef enum logic [1:0] {
    CfgStepSize      = 2'd0,
    CfgFeedRate      = 2'd1,
    CfgConversionRate = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    fix_t conc_x;
    fix_t conc_y;
  } in_item_t;

  typedef struct packed {
    fix_t next_x;
    fix_t next_y;
    logic saturated;
  } out_item_t;

  // coefficients in data format
  typedef struct packed {
    fix_t h;
    fix_t a;
    fix_t b;
    fix_t b1;
  } coef_t;

  // per-item state carried down the pipeline
  typedef struct packed {
    logic valid;
    fix_t x;
    fix_t y;
    fix_t px;
    fix_t py;
    fix_t ax;
    fix_t ay;
    logic sat;
  } carry_t;

  typedef struct packed {
    fix_t val;
    logic clip;
  } sat_t;

  // saturating add
  function automatic sat_t sat_add(input fix_t a, input fix_t b);
    logic [DataWidth:0] s;
    sat_t r;
    s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      r.val  = s[DataWidth] ? FixMin : FixMax;
      r.clip = 1'b1;
    end else begin
      r.val  = s[DataWidth-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // saturating subtract
  function automatic sat_t sat_sub(input fix_t a, input fix_t b);
    logic [DataWidth:0] s;
    sat_t r;
    s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
    if (s[DataWidth] != s[DataWidth-1]) begin
      r.val  = s[DataWidth] ? FixMin : FixMax;
      r.clip = 1'b1;
    end else begin
      r.val  = s[DataWidth-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // full signed product
  function automatic prod_t mul_full(input fix_t a, input fix_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // drop fraction bits rounding down, then clip to the data range
  function automatic sat_t sat_scale(input prod_t p, input int unsigned frac);
    prod_t q;
    sat_t r;
    q = p >>> frac;
    if ((&q[2*DataWidth-1:DataWidth-1]) || !(|q[2*DataWidth-1:DataWidth-1])) begin
      r.val  = q[DataWidth-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = q[2*DataWidth-1] ? FixMin : FixMax;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ design/brusselator_rk4_step_unit.sv @@
// Top level of the Brusselator RK4 step unit: config registers, four rate
// evaluation pipelines and the final divide-by-six and update stages.
// Depends on brk4_pkg and brk4_rate_eval.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | in_data_i  (conc_x, conc_y)
//  out     | output    | out_valid_o / out_stall_i| out_data_o (next_x, next_y, saturated)
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One item enters per cycle while the input is not stalled; each passes
// four five-stage rate evaluations, then three final stages, to a valid result.
// Reset clears all valid bits and loads the config registers with defaults.
// One pipeline enable moves every stage together: it is held while the output
// register is full and stalled, and then the input is stalled as well.
module brusselator_rk4_step_unit #(
  parameter int FRAC_BITS = brk4_pkg::FracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  brk4_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output brk4_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [brk4_pkg::RateWidth-1:0]      cfg_wdata_i
);

  localparam int DW   = brk4_pkg::DataWidth;
  localparam int RW   = brk4_pkg::RateWidth + FRAC_BITS;
  localparam int RS   = DW + 1;
  localparam logic signed [DW+1:0] Recip = (DW+2)'(((DW+3)'(1) << RS) / 3);
  localparam brk4_pkg::fix_t One = brk4_pkg::fix_t'(1) << FRAC_BITS;

  logic [brk4_pkg::StepWidth-1:0] step_size_q;
  logic [brk4_pkg::RateWidth-1:0] feed_rate_q, conversion_rate_q;

  brk4_pkg::coef_t  coef;
  brk4_pkg::sat_t   ch, ca, cb, cb1;
  brk4_pkg::carry_t stage_c [5];
  brk4_pkg::carry_t f1_q, f2_q;
  logic signed [2*DW+1:0] f1_px_q, f1_py_q;
  brk4_pkg::fix_t   f1_ux_q, f1_uy_q, f2_qx_q, f2_qy_q, qx, qy;
  brk4_pkg::sat_t   nx, ny;
  brk4_pkg::fix_t   ux, uy;
  logic             adv;
  logic             out_valid_q;
  brk4_pkg::out_item_t out_q;

  // register value to data format, clipped to the positive limit
  function automatic brk4_pkg::sat_t to_fmt(input logic [brk4_pkg::RateWidth-1:0] r);
    logic [RW-1:0] w;
    brk4_pkg::sat_t res;
    w = (RW'(r) << FRAC_BITS) >> brk4_pkg::RegFrac;
    if (w > RW'(brk4_pkg::FixMax)) begin
      res.val  = brk4_pkg::FixMax;
      res.clip = 1'b1;
    end else begin
      res.val  = w[DW-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

  // exact floor divide by three of a floor-halved value
  function automatic brk4_pkg::fix_t fix_third(input logic signed [2*DW+1:0] p,
                                               input brk4_pkg::fix_t u);
    logic signed [2*DW+1:0] q0w;
    logic signed [DW+1:0]   q0, rem;
    q0w = p >>> RS;
    q0  = q0w[DW+1:0];
    rem = {{2{u[DW-1]}}, u} - ((q0 <<< 1) + q0);
    if (rem >= (DW+2)'(3)) begin
      q0 = q0 + (DW+2)'(1);
    end
    return q0[DW-1:0];
  endfunction

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q       <= brk4_pkg::StepWidth'(16777);
      feed_rate_q       <= brk4_pkg::RateWidth'(58720256);
      conversion_rate_q <= brk4_pkg::RateWidth'(21810381);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        brk4_pkg::CfgStepSize:       step_size_q       <= cfg_wdata_i[brk4_pkg::StepWidth-1:0];
        brk4_pkg::CfgFeedRate:       feed_rate_q       <= cfg_wdata_i;
        brk4_pkg::CfgConversionRate: conversion_rate_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // coefficients in data format
  always_comb begin
    ch   = to_fmt(brk4_pkg::RateWidth'(step_size_q));
    ca   = to_fmt(feed_rate_q);
    cb   = to_fmt(conversion_rate_q);
    cb1  = brk4_pkg::sat_add(cb.val, One);
    coef = '{h: ch.val, a: ca.val, b: cb.val, b1: cb1.val};
  end

  // pipeline enable
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // entry state
  assign stage_c[0] = '{valid: in_valid_i, x: in_data_i.conc_x, y: in_data_i.conc_y,
                        px: in_data_i.conc_x, py: in_data_i.conc_y, ax: '0, ay: '0,
                        sat: ch.clip | ca.clip | cb.clip | cb1.clip};

  // four rate evaluations
  for (genvar g = 0; g < 4; g++) begin : g_eval
    brk4_rate_eval #(
      .FRAC_BITS (FRAC_BITS),
      .K_INDEX   (g + 1)
    ) u_eval (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .coef_i  (coef),
      .carry_i (stage_c[g]),
      .carry_o (stage_c[g+1])
    );
  end

  // final stages: halve, reciprocal multiply, correct, add
  assign ux = stage_c[4].ax >>> 1;
  assign uy = stage_c[4].ay >>> 1;
  assign qx = fix_third(f1_px_q, f1_ux_q);
  assign qy = fix_third(f1_py_q, f1_uy_q);
  assign nx = brk4_pkg::sat_add(f2_q.x, f2_qx_q);
  assign ny = brk4_pkg::sat_add(f2_q.y, f2_qy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q        <= '0;
      f2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      f1_q        <= stage_c[4];
      f2_q        <= f1_q;
      out_valid_q <= f2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_px_q <= (2*DW+2)'(ux) * (2*DW+2)'(Recip);
      f1_py_q <= (2*DW+2)'(uy) * (2*DW+2)'(Recip);
      f1_ux_q <= ux;
      f1_uy_q <= uy;
      f2_qx_q <= qx;
      f2_qy_q <= qy;
      out_q   <= '{next_x: nx.val, next_y: ny.val,
                   saturated: f2_q.sat | nx.clip | ny.clip};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/brk4_rate_eval.sv @@
// One rate evaluation plus one RK4 stage update, five register stages.
// Depends on brk4_pkg.
module brk4_rate_eval #(
  parameter int FRAC_BITS = brk4_pkg::FracBits,
  parameter int K_INDEX   = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  brk4_pkg::coef_t   coef_i,
  input  brk4_pkg::carry_t  carry_i,
  output brk4_pkg::carry_t  carry_o
);

  brk4_pkg::carry_t s1_q, s2_q, s3_q, s4_q, s5_q;
  brk4_pkg::carry_t s2_d, s5_d;
  brk4_pkg::prod_t  pxx_q, pbx1_q, pbx_q, px2y_q, pkx_q, pky_q;
  brk4_pkg::prod_t  px2y_d;
  brk4_pkg::fix_t   t_q, bx_q, dx_q, dy_q;
  brk4_pkg::sat_t   xx, bx1, bx, t, x2y, dx, dy, kx, ky;
  brk4_pkg::sat_t   dblx, dbly, accx, accy, ptx, pty;

  // stage 2: scale products, form a-(b+1)x and x*x*y product
  always_comb begin
    xx     = brk4_pkg::sat_scale(pxx_q, FRAC_BITS);
    bx1    = brk4_pkg::sat_scale(pbx1_q, FRAC_BITS);
    bx     = brk4_pkg::sat_scale(pbx_q, FRAC_BITS);
    t      = brk4_pkg::sat_sub(coef_i.a, bx1.val);
    px2y_d = brk4_pkg::mul_full(xx.val, s1_q.py);
    s2_d     = s1_q;
    s2_d.sat = s1_q.sat | xx.clip | bx1.clip | bx.clip | t.clip;
  end

  // stage 3: rates
  always_comb begin
    x2y = brk4_pkg::sat_scale(px2y_q, FRAC_BITS);
    dx  = brk4_pkg::sat_add(t_q, x2y.val);
    dy  = brk4_pkg::sat_sub(bx_q, x2y.val);
  end

  // stage 5: k values, running sum and next evaluation point
  always_comb begin
    kx   = brk4_pkg::sat_scale(pkx_q, FRAC_BITS);
    ky   = brk4_pkg::sat_scale(pky_q, FRAC_BITS);
    dblx = brk4_pkg::sat_add(kx.val, kx.val);
    dbly = brk4_pkg::sat_add(ky.val, ky.val);
    s5_d = s4_q;
    s5_d.sat = s4_q.sat | kx.clip | ky.clip;
    unique case (K_INDEX)
      1: begin
        accx = '{val: kx.val, clip: 1'b0};
        accy = '{val: ky.val, clip: 1'b0};
        ptx  = brk4_pkg::sat_add(s4_q.x, kx.val >>> 1);
        pty  = brk4_pkg::sat_add(s4_q.y, ky.val >>> 1);
        s5_d.sat = s5_d.sat | ptx.clip | pty.clip;
      end
      2: begin
        accx = brk4_pkg::sat_add(s4_q.ax, dblx.val);
        accy = brk4_pkg::sat_add(s4_q.ay, dbly.val);
        ptx  = brk4_pkg::sat_add(s4_q.x, kx.val >>> 1);
        pty  = brk4_pkg::sat_add(s4_q.y, ky.val >>> 1);
        s5_d.sat = s5_d.sat | dblx.clip | dbly.clip | accx.clip | accy.clip
                   | ptx.clip | pty.clip;
      end
      3: begin
        accx = brk4_pkg::sat_add(s4_q.ax, dblx.val);
        accy = brk4_pkg::sat_add(s4_q.ay, dbly.val);
        ptx  = brk4_pkg::sat_add(s4_q.x, kx.val);
        pty  = brk4_pkg::sat_add(s4_q.y, ky.val);
        s5_d.sat = s5_d.sat | dblx.clip | dbly.clip | accx.clip | accy.clip
                   | ptx.clip | pty.clip;
      end
      default: begin
        accx = brk4_pkg::sat_add(s4_q.ax, kx.val);
        accy = brk4_pkg::sat_add(s4_q.ay, ky.val);
        ptx  = '{val: s4_q.px, clip: 1'b0};
        pty  = '{val: s4_q.py, clip: 1'b0};
        s5_d.sat = s5_d.sat | accx.clip | accy.clip;
      end
    endcase
    s5_d.ax = accx.val;
    s5_d.ay = accy.val;
    s5_d.px = ptx.val;
    s5_d.py = pty.val;
  end

  // control: item state per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      s5_q <= '0;
    end else if (en_i) begin
      s1_q <= carry_i;
      s2_q <= s2_d;
      s3_q <= '{valid: s2_q.valid, x: s2_q.x, y: s2_q.y, px: s2_q.px, py: s2_q.py,
                ax: s2_q.ax, ay: s2_q.ay,
                sat: s2_q.sat | x2y.clip | dx.clip | dy.clip};
      s4_q <= s3_q;
      s5_q <= s5_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxx_q  <= brk4_pkg::mul_full(carry_i.px, carry_i.px);
      pbx1_q <= brk4_pkg::mul_full(coef_i.b1, carry_i.px);
      pbx_q  <= brk4_pkg::mul_full(coef_i.b, carry_i.px);
      px2y_q <= px2y_d;
      t_q    <= t.val;
      bx_q   <= bx.val;
      dx_q   <= dx.val;
      dy_q   <= dy.val;
      pkx_q  <= brk4_pkg::mul_full(coef_i.h, dx_q);
      pky_q  <= brk4_pkg::mul_full(coef_i.h, dy_q);
    end
  end

  assign carry_o = s5_q;

endmodule

@@ tb/tb.sv @@
// Testbench for the Brusselator RK4 step unit: streams concentration pairs
// through a valid/stall channel and checks each result against a local model.
// Depends on brk4_pkg and brusselator_rk4_step_unit.
module tb;

  localparam int Latency = 23;
  localparam int WatchLimit = 20000;
  localparam longint LMax = 64'sd2147483647;
  localparam longint LMin = -64'sd2147483648;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  brk4_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  brk4_pkg::out_item_t out_data_o;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [brk4_pkg::RateWidth-1:0] cfg_wdata_i;

  brusselator_rk4_step_unit dut (.*);

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // predictor copy of the config registers
  longint unsigned step_reg, feed_reg, conv_reg;
  bit clip_flag;
  brk4_pkg::out_item_t expected_q[$];
  int errors;
  int idle_cycles;
  bit quiet_rx;
  bit hold_rx;

  function automatic longint clamp32(longint v);
    if (v > LMax) begin clip_flag = 1; return LMax; end
    if (v < LMin) begin clip_flag = 1; return LMin; end
    return v;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp32(a - b);
  endfunction

  // product with floor on the dropped fraction bits
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] p;
    p = $signed(128'(a)) * $signed(128'(b));
    p = p >>> brk4_pkg::FracBits;
    if (p > LMax) begin clip_flag = 1; return LMax; end
    if (p < LMin) begin clip_flag = 1; return LMin; end
    return longint'(p);
  endfunction

  function automatic longint floor_div(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-(v + 1)) / d) - 1;
  endfunction

  function automatic longint reg_fmt(longint unsigned r);
    if (r > LMax) begin clip_flag = 1; return LMax; end
    return longint'(r);
  endfunction

  function automatic void rates(longint x, longint y, longint a, longint b,
                                longint b1, output longint dx, output longint dy);
    longint x2y;
    x2y = fx_mul(fx_mul(x, x), y);
    dx = fx_add(fx_sub(a, fx_mul(b1, x)), x2y);
    dy = fx_sub(fx_mul(b, x), x2y);
  endfunction

  function automatic brk4_pkg::out_item_t rk4_step(brk4_pkg::in_item_t it);
    longint h, a, b, b1, x, y, fx, fy;
    longint k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y, sx, sy;
    brk4_pkg::out_item_t r;
    clip_flag = 0;
    h = reg_fmt(step_reg);
    a = reg_fmt(feed_reg);
    b = reg_fmt(conv_reg);
    b1 = fx_add(b, 64'sd1 <<< brk4_pkg::FracBits);
    x = longint'(it.conc_x);
    y = longint'(it.conc_y);
    rates(x, y, a, b, b1, fx, fy);
    k1x = fx_mul(h, fx); k1y = fx_mul(h, fy);
    rates(fx_add(x, floor_div(k1x, 2)), fx_add(y, floor_div(k1y, 2)), a, b, b1, fx, fy);
    k2x = fx_mul(h, fx); k2y = fx_mul(h, fy);
    rates(fx_add(x, floor_div(k2x, 2)), fx_add(y, floor_div(k2y, 2)), a, b, b1, fx, fy);
    k3x = fx_mul(h, fx); k3y = fx_mul(h, fy);
    rates(fx_add(x, k3x), fx_add(y, k3y), a, b, b1, fx, fy);
    k4x = fx_mul(h, fx); k4y = fx_mul(h, fy);
    sx = fx_add(fx_add(fx_add(k1x, fx_add(k2x, k2x)), fx_add(k3x, k3x)), k4x);
    sy = fx_add(fx_add(fx_add(k1y, fx_add(k2y, k2y)), fx_add(k3y, k3y)), k4y);
    r.next_x = brk4_pkg::fix_t'(fx_add(x, floor_div(sx, 6)));
    r.next_y = brk4_pkg::fix_t'(fx_add(y, floor_div(sy, 6)));
    r.saturated = clip_flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // output side: random stall, long holds on request
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_rx || (!quiet_rx && ($urandom_range(99) < 21));
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("watchdog: no transfer for %0d cycles", WatchLimit);
        $display("tb: done, errors");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          brk4_pkg::out_item_t e;
          e = expected_q.pop_front();
          if (out_data_o.next_x !== e.next_x)
            report_mismatch("next_x", out_data_o.next_x, e.next_x);
          if (out_data_o.next_y !== e.next_y)
            report_mismatch("next_y", out_data_o.next_y, e.next_y);
          if (out_data_o.saturated !== e.saturated)
            report_mismatch("saturated", out_data_o.saturated, e.saturated);
        end
      end
    end
  end

  task automatic write_cfg(brk4_pkg::cfg_idx_e idx, longint unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val[brk4_pkg::RateWidth-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      brk4_pkg::CfgStepSize: step_reg = val & 64'h1FFFFFF;
      brk4_pkg::CfgFeedRate: feed_reg = val & 64'h1FFFFFFF;
      default: conv_reg = val & 64'h1FFFFFFF;
    endcase
  endtask

  // wait for all results, then idle with the pipeline empty
  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  // one item: optional idle gap, then hold valid until the transfer
  task automatic send_item(brk4_pkg::in_item_t it, bit gaps);
    @(negedge clk_i);
    while (gaps && ($urandom_range(99) < 21)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(rk4_step(it));
  endtask

  function automatic brk4_pkg::fix_t rand_conc();
    case ($urandom_range(3))
      0: return brk4_pkg::fix_t'($urandom);
      1: return brk4_pkg::fix_t'($signed($urandom_range(16 << 24)) - (8 << 24));
      2: return brk4_pkg::fix_t'($urandom_range(6 << 24));
      default: return brk4_pkg::fix_t'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  typedef struct {
    brk4_pkg::in_item_t it;
    bit known;
    brk4_pkg::out_item_t want;
  } stim_row_t;

  stim_row_t directed[$];

  initial begin
    stim_row_t row;
    brk4_pkg::in_item_t it;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = brk4_pkg::CfgStepSize;
    cfg_wdata_i = '0;
    errors = 0;
    idle_cycles = 0;
    quiet_rx = 1'b0;
    hold_rx = 1'b0;
    step_reg = 16777; feed_reg = 58720256; conv_reg = 21810381;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows; the h = 0 row below has its result typed in
    directed.push_back('{'{brk4_pkg::FixMax, brk4_pkg::FixMax}, 0, '0});
    directed.push_back('{'{brk4_pkg::FixMin, brk4_pkg::FixMin}, 0, '0});
    directed.push_back('{'{brk4_pkg::FixMax, brk4_pkg::FixMin}, 0, '0});
    directed.push_back('{'{brk4_pkg::FixMin, brk4_pkg::FixMax}, 0, '0});
    directed.push_back('{'{32'sd0, 32'sd0}, 0, '0});
    directed.push_back('{'{32'sd58720256, 32'sd6710886}, 0, '0});
    directed.push_back('{'{32'sh01000000, 32'sh01000000}, 0, '0});
    directed.push_back('{'{-32'sd1, -32'sd1}, 0, '0});
    directed.push_back('{'{32'sh55555555, 32'shAAAAAAAA}, 0, '0});
    directed.push_back('{'{32'shAAAAAAAA, 32'sh55555555}, 0, '0});
    foreach (directed[i]) send_item(directed[i].it, 0);
    @(negedge clk_i); in_valid_i <= 1'b0;
    drain();

    // h = 0 keeps the pair unchanged
    write_cfg(brk4_pkg::CfgStepSize, 0);
    row = '{'{32'sh00800000, -32'sh00400000}, 1, '{32'sh00800000, -32'sh00400000, 1'b0}};
    send_item(row.it, 0);
    @(negedge clk_i); in_valid_i <= 1'b0;
    drain();
    if (expected_q.size() == 0 && rk4_step(row.it) !== row.want)
      report_mismatch("h=0 row", rk4_step(row.it).next_x, row.want.next_x);

    // extremes of every register
    write_cfg(brk4_pkg::CfgStepSize, 25'h1000000);
    write_cfg(brk4_pkg::CfgFeedRate, 29'h10000000);
    write_cfg(brk4_pkg::CfgConversionRate, 29'h10000000);
    foreach (directed[i]) send_item(directed[i].it, 0);
    @(negedge clk_i); in_valid_i <= 1'b0;
    drain();
    write_cfg(brk4_pkg::CfgStepSize, 25'h1FFFFFF);
    write_cfg(brk4_pkg::CfgFeedRate, 29'h1FFFFFFF);
    write_cfg(brk4_pkg::CfgConversionRate, 0);
    for (int i = 0; i < 5; i++) send_item(directed[i].it, 0);
    @(negedge clk_i); in_valid_i <= 1'b0;
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_cfg(brk4_pkg::CfgStepSize, 16777);
          write_cfg(brk4_pkg::CfgFeedRate, 58720256);
          write_cfg(brk4_pkg::CfgConversionRate, 21810381);
        end
        5: begin
          write_cfg(brk4_pkg::CfgStepSize, 0);
          write_cfg(brk4_pkg::CfgFeedRate, 0);
          write_cfg(brk4_pkg::CfgConversionRate, 0);
        end
        default: begin
          write_cfg(brk4_pkg::CfgStepSize, $urandom_range(25'h1FFFFFF));
          write_cfg(brk4_pkg::CfgFeedRate, $urandom_range(29'h1FFFFFFF));
          write_cfg(brk4_pkg::CfgConversionRate, $urandom_range(29'h1FFFFFFF));
        end
      endcase
      quiet_rx = (ph == 1);
      for (int n = 0; n < 250; n++) begin
        it.conc_x = rand_conc();
        it.conc_y = rand_conc();
        // long receiver hold while the sender keeps offering
        if (ph == 2 && n == 50) fork
          begin
            hold_rx = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_rx = 1'b0;
          end
        join_none
        // sender pause until every result is back
        if (ph == 3 && n == 100) begin
          @(negedge clk_i); in_valid_i <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk_i);
        end
        send_item(it, (ph != 1));
      end
      @(negedge clk_i); in_valid_i <= 1'b0;
      drain();
    end
    quiet_rx = 1'b0;

    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
